// ===== hw/rtl/mlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpt_pkg
// Shared types, constants and helper functions of the Morse letter pulse
// timer: digit places, symbol kinds, register indexes and the letter record.
// ----------------------------------------------------------------------------
package mlpt_pkg;

  localparam int CODE_DIGITS = 4;
  localparam int CODE_W      = 14;
  localparam int DUR_W       = 16;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam int DIGIT_IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  // Reciprocal scaling for the constant divisions in the front end.
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam logic [DUR_W-1:0] DOT_TIME_RST        = DUR_W'(300);
  localparam logic [DUR_W-1:0] DASH_TIME_RST       = DUR_W'(1000);
  localparam logic [DUR_W-1:0] SYMBOL_GAP_TIME_RST = DUR_W'(400);
  localparam logic [DUR_W-1:0] LETTER_GAP_TIME_RST = DUR_W'(1500);

  typedef enum logic [KIND_W-1:0] {
    KIND_GAP  = 2'd0,
    KIND_DOT  = 2'd1,
    KIND_DASH = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOT_TIME        = 2'd0,
    REG_DASH_TIME       = 2'd1,
    REG_SYMBOL_GAP_TIME = 2'd2,
    REG_LETTER_GAP_TIME = 2'd3
  } cfg_reg_t;

  // One classified letter: a symbol per decimal place, thousands first.
  typedef struct packed {
    kind_t [CODE_DIGITS-1:0] syms;
    logic                    last;
  } letter_t;

  typedef struct packed {
    logic [DUR_W-1:0] dot_time;
    logic [DUR_W-1:0] dash_time;
    logic [DUR_W-1:0] symbol_gap_time;
    logic [DUR_W-1:0] letter_gap_time;
  } timing_t;

  // Decimal weight of digit d, where digit 0 is the most significant one.
  function automatic int place_of(input int d);
    int p;
    p = 1;
    for (int k = d + 1; k < CODE_DIGITS; k++) begin
      p = p * 10;
    end
    return p;
  endfunction

  function automatic kind_t classify(input logic [CODE_W-1:0] q);
    kind_t k;
    k = KIND_GAP;
    if (q == CODE_W'(1)) begin
      k = KIND_DOT;
    end else if (q == CODE_W'(2)) begin
      k = KIND_DASH;
    end
    return k;
  endfunction

endpackage

// ===== hw/rtl/mlpt_in_if.sv =====
// ----------------------------------------------------------------------------
// mlpt_in_if
// Letter channel: one coded letter and its end-of-message flag per item.
// ----------------------------------------------------------------------------
interface mlpt_in_if;
  logic                       valid;
  logic                       ready;
  logic [mlpt_pkg::CODE_W-1:0] letter_code;
  logic                       last_letter;

  modport source (output valid, output letter_code, output last_letter, input ready);
  modport sink   (input valid, input letter_code, input last_letter, output ready);
endinterface

// ===== hw/rtl/mlpt_out_if.sv =====
// ----------------------------------------------------------------------------
// mlpt_out_if
// Interval channel: one LED pulse or gap per item.
// ----------------------------------------------------------------------------
interface mlpt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        led_on;
  logic [mlpt_pkg::DUR_W-1:0]  duration_ms;
  logic [mlpt_pkg::KIND_W-1:0] symbol_kind;
  logic                        letter_end;
  logic                        message_end;

  modport source (output valid, output led_on, output duration_ms, output symbol_kind,
                  output letter_end, output message_end, input ready);
  modport sink   (input valid, input led_on, input duration_ms, input symbol_kind,
                  input letter_end, input message_end, output ready);
endinterface

// ===== hw/rtl/morse_letter_pulse_timer_top.sv =====
// ----------------------------------------------------------------------------
// morse_letter_pulse_timer_top
// Morse keyer for one letter at a time: decimal coded letters in, LED
// pulse and gap intervals out, with four programmable durations.
//
//   Channel     Direction  Handshake        Payload
//   letter_in   in         valid / ready    letter_code, last_letter
//   pulse_out   out        valid / ready    led_on, duration_ms, symbol_kind,
//                                           letter_end, message_end
//   cfg         in         cfg_we           cfg_index, cfg_data
//
// A letter yields one to nine intervals, twice the number of dots and dashes
// plus one, offered one per output cycle unless the output stalls, through
// the single output register. The front end is an eight-stage digit
// pipeline; behind it, the first interval of a letter passes through the
// queue, the letter register and the output register. Reset is synchronous
// and restores the default durations. Input and output stall independently
// through a two-letter queue.
// ----------------------------------------------------------------------------
module morse_letter_pulse_timer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mlpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlpt_pkg::DUR_W-1:0]      cfg_data,
  mlpt_in_if.sink                         letter_in,
  mlpt_out_if.source                      pulse_out
);

  mlpt_pkg::timing_t timing;
  logic              push_valid;
  logic              push_ready;
  mlpt_pkg::letter_t push_data;
  logic              head_valid;
  logic              head_pop;
  mlpt_pkg::letter_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.dot_time        <= mlpt_pkg::DOT_TIME_RST;
      timing.dash_time       <= mlpt_pkg::DASH_TIME_RST;
      timing.symbol_gap_time <= mlpt_pkg::SYMBOL_GAP_TIME_RST;
      timing.letter_gap_time <= mlpt_pkg::LETTER_GAP_TIME_RST;
    end else if (cfg_we) begin
      unique case (mlpt_pkg::cfg_reg_t'(cfg_index))
        mlpt_pkg::REG_DOT_TIME:        timing.dot_time        <= cfg_data;
        mlpt_pkg::REG_DASH_TIME:       timing.dash_time       <= cfg_data;
        mlpt_pkg::REG_SYMBOL_GAP_TIME: timing.symbol_gap_time <= cfg_data;
        mlpt_pkg::REG_LETTER_GAP_TIME: timing.letter_gap_time <= cfg_data;
        default: ;
      endcase
    end
  end

  mlpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .letter_in  (letter_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mlpt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_data   (head)
  );

  mlpt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head       (head),
    .timing     (timing),
    .pulse_out  (pulse_out)
  );

endmodule

// ===== hw/rtl/mlpt_front.sv =====
// ----------------------------------------------------------------------------
// mlpt_front
// Splits each letter code into decimal digits and classifies every digit as
// dot, dash or nothing. Two pipeline stages per digit: quotient, then
// remainder and classification.
// ----------------------------------------------------------------------------
module mlpt_front (
  input  logic                 clk,
  input  logic                 rst,
  mlpt_in_if.sink              letter_in,
  output logic                 push_valid,
  input  logic                 push_ready,
  output mlpt_pkg::letter_t    push_data
);

  localparam int D = mlpt_pkg::CODE_DIGITS;
  localparam int W = mlpt_pkg::CODE_W;

  logic                 en;
  logic [D-1:0]         va;
  logic [D-1:0]         vb;
  logic [D-1:0]         src_v;
  logic [W-1:0]         src_rem [D];
  mlpt_pkg::letter_t    src_ltr [D];
  logic [W-1:0]         rem_a   [D];
  logic [W-1:0]         q_a     [D];
  mlpt_pkg::letter_t    ltr_a   [D];
  logic [W-1:0]         rem_b   [D];
  mlpt_pkg::letter_t    ltr_b   [D];

  // The whole pipeline moves together; it only holds when its tail is stuck.
  assign en              = !vb[D-1] || push_ready;
  assign letter_in.ready = en;
  assign push_valid      = vb[D-1];
  assign push_data       = ltr_b[D-1];

  for (genvar d = 0; d < D; d++) begin : g_digit
    localparam int PLACE = mlpt_pkg::place_of(d);
    localparam logic [mlpt_pkg::RECIP_W-1:0] RECIP_C = mlpt_pkg::RECIP_W'(
      ((64'd1 << mlpt_pkg::RECIP_SHIFT) + 64'(PLACE) - 64'd1) / 64'(PLACE));
    localparam logic [W-1:0] PLACE_C = W'(PLACE);

    logic [W+mlpt_pkg::RECIP_W-1:0] prod;
    logic [W-1:0]                   q_calc;
    logic [W-1:0]                   qp;
    mlpt_pkg::letter_t              ltr_nx;

    if (d == 0) begin : g_head
      assign src_v[d]        = letter_in.valid;
      assign src_rem[d]      = letter_in.letter_code;
      assign src_ltr[d].syms = {D{mlpt_pkg::KIND_GAP}};
      assign src_ltr[d].last = letter_in.last_letter;
    end else begin : g_link
      assign src_v[d]   = vb[d-1];
      assign src_rem[d] = rem_b[d-1];
      assign src_ltr[d] = ltr_b[d-1];
    end

    // Quotient by reciprocal multiplication; exact for every 14-bit value.
    assign prod   = (W+mlpt_pkg::RECIP_W)'(src_rem[d]) * (W+mlpt_pkg::RECIP_W)'(RECIP_C);
    assign q_calc = prod[mlpt_pkg::RECIP_SHIFT +: W];
    assign qp     = W'(q_a[d] * PLACE_C);

    always_comb begin
      ltr_nx         = ltr_a[d];
      ltr_nx.syms[d] = mlpt_pkg::classify(q_a[d]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        va[d] <= 1'b0;
        vb[d] <= 1'b0;
      end else if (en) begin
        va[d] <= src_v[d];
        vb[d] <= va[d];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[d] <= src_rem[d];
        q_a[d]   <= q_calc;
        ltr_a[d] <= src_ltr[d];
        rem_b[d] <= rem_a[d] - qp;
        ltr_b[d] <= ltr_nx;
      end
    end
  end

endmodule

// ===== hw/rtl/mlpt_queue.sv =====
// ----------------------------------------------------------------------------
// mlpt_queue
// Short register queue of classified letters between front and back end.
// ----------------------------------------------------------------------------
module mlpt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  mlpt_pkg::letter_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output mlpt_pkg::letter_t pop_data
);

  localparam int PTR_W = (mlpt_pkg::QUEUE_DEPTH > 1) ? $clog2(mlpt_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mlpt_pkg::QUEUE_DEPTH + 1);

  mlpt_pkg::letter_t entries [mlpt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(mlpt_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(mlpt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(mlpt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/mlpt_back.sv =====
// ----------------------------------------------------------------------------
// mlpt_back
// Plays out one classified letter as pulses and gaps, one interval per
// cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module mlpt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  output logic              head_pop,
  input  mlpt_pkg::letter_t head,
  input  mlpt_pkg::timing_t timing,
  mlpt_out_if.source        pulse_out
);

  localparam int D = mlpt_pkg::CODE_DIGITS;

  mlpt_pkg::kind_t [D-1:0]        syms;
  logic                           last;
  logic                           cur_valid;
  logic                           phase;
  logic                           take;
  logic                           emit;
  logic                           any_sym;
  logic [mlpt_pkg::DIGIT_IDX_W-1:0] first;
  mlpt_pkg::kind_t                first_kind;
  logic [mlpt_pkg::DUR_W-1:0]     pulse_dur;
  logic                           letter_done;

  assign take        = !pulse_out.valid || pulse_out.ready;
  assign emit        = cur_valid && take;
  assign letter_done = emit && !any_sym;
  assign head_pop    = head_valid && (!cur_valid || letter_done);

  // Earliest place that still holds a dot or a dash.
  always_comb begin
    any_sym = 1'b0;
    first   = '0;
    for (int d = D - 1; d >= 0; d--) begin
      if (syms[d] != mlpt_pkg::KIND_GAP) begin
        any_sym = 1'b1;
        first   = mlpt_pkg::DIGIT_IDX_W'(d);
      end
    end
  end

  assign first_kind = syms[first];

  always_comb begin
    case (first_kind)
      mlpt_pkg::KIND_DASH: pulse_dur = timing.dash_time;
      default:             pulse_dur = timing.dot_time;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (head_pop) begin
        cur_valid <= 1'b1;
        phase     <= 1'b0;
      end else if (letter_done) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        phase <= !phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      syms <= head.syms;
      last <= head.last;
    end else if (emit && any_sym && phase) begin
      // The gap after a symbol retires that symbol.
      syms[first] <= mlpt_pkg::KIND_GAP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_out.valid <= 1'b0;
    end else if (take) begin
      pulse_out.valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (any_sym && !phase) begin
        pulse_out.led_on      <= 1'b1;
        pulse_out.duration_ms <= pulse_dur;
        pulse_out.symbol_kind <= first_kind;
        pulse_out.letter_end  <= 1'b0;
        pulse_out.message_end <= 1'b0;
      end else if (any_sym) begin
        pulse_out.led_on      <= 1'b0;
        pulse_out.duration_ms <= timing.symbol_gap_time;
        pulse_out.symbol_kind <= mlpt_pkg::KIND_GAP;
        pulse_out.letter_end  <= 1'b0;
        pulse_out.message_end <= 1'b0;
      end else begin
        pulse_out.led_on      <= 1'b0;
        pulse_out.duration_ms <= timing.letter_gap_time;
        pulse_out.symbol_kind <= mlpt_pkg::KIND_GAP;
        pulse_out.letter_end  <= 1'b1;
        pulse_out.message_end <= last;
      end
    end
  end

endmodule

// ===== bench/morse_letter_pulse_timer_top_tb.sv =====
// ----------------------------------------------------------------------------
// morse_letter_pulse_timer_top_tb
// Self-checking bench for the Morse letter pulse timer. Coded letters are
// sent with random gaps and the intervals are taken with random back-pressure.
// Each interval is compared with a prediction made when its letter is
// accepted. The four durations are reprogrammed between phases, including
// all-zero and all-ones settings.
// ----------------------------------------------------------------------------
module morse_letter_pulse_timer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 92;
  localparam int TAIL_CYCLES  = 20;

  typedef struct packed {
    logic                       led_on;
    logic [mlpt_pkg::DUR_W-1:0] duration_ms;
    mlpt_pkg::kind_t            symbol_kind;
    logic                       letter_end;
    logic                       message_end;
  } interval_t;

  // Expands each accepted letter into its intervals and checks them in order.
  class interval_ledger;
    mlpt_pkg::timing_t timing;
    interval_t         awaited[$];
    int unsigned       letters;
    int unsigned       intervals;
    int unsigned       faults;

    function new();
      timing.dot_time        = mlpt_pkg::DOT_TIME_RST;
      timing.dash_time       = mlpt_pkg::DASH_TIME_RST;
      timing.symbol_gap_time = mlpt_pkg::SYMBOL_GAP_TIME_RST;
      timing.letter_gap_time = mlpt_pkg::LETTER_GAP_TIME_RST;
    endfunction

    function void report(string what);
      faults++;
      if (faults <= 100) begin
        $display("MISMATCH: %s", what);
      end
    endfunction

    function void set_reg(mlpt_pkg::cfg_reg_t idx, logic [mlpt_pkg::DUR_W-1:0] v);
      case (idx)
        mlpt_pkg::REG_DOT_TIME:        timing.dot_time = v;
        mlpt_pkg::REG_DASH_TIME:       timing.dash_time = v;
        mlpt_pkg::REG_SYMBOL_GAP_TIME: timing.symbol_gap_time = v;
        mlpt_pkg::REG_LETTER_GAP_TIME: timing.letter_gap_time = v;
        default: ;
      endcase
    endfunction

    function interval_t make(logic led, logic [mlpt_pkg::DUR_W-1:0] dur,
                             mlpt_pkg::kind_t kind, logic lend, logic mend);
      interval_t iv;
      iv.led_on      = led;
      iv.duration_ms = dur;
      iv.symbol_kind = kind;
      iv.letter_end  = lend;
      iv.message_end = mend;
      return iv;
    endfunction

    function void note_letter(logic [mlpt_pkg::CODE_W-1:0] code, logic last);
      int unsigned rem;
      int unsigned place;
      int unsigned q;
      rem   = 32'(code);
      place = 1;
      for (int d = 1; d < mlpt_pkg::CODE_DIGITS; d++) begin
        place = place * 10;
      end
      // A leading quotient above nine (codes past 9999) is simply skipped.
      for (int d = 0; d < mlpt_pkg::CODE_DIGITS; d++) begin
        if (rem == 0 || place == 0) break;
        q     = rem / place;
        rem   = rem % place;
        place = place / 10;
        if (q == 1) begin
          awaited.push_back(make(1'b1, timing.dot_time, mlpt_pkg::KIND_DOT, 1'b0, 1'b0));
          awaited.push_back(make(1'b0, timing.symbol_gap_time, mlpt_pkg::KIND_GAP,
                                 1'b0, 1'b0));
        end else if (q == 2) begin
          awaited.push_back(make(1'b1, timing.dash_time, mlpt_pkg::KIND_DASH, 1'b0, 1'b0));
          awaited.push_back(make(1'b0, timing.symbol_gap_time, mlpt_pkg::KIND_GAP,
                                 1'b0, 1'b0));
        end
      end
      awaited.push_back(make(1'b0, timing.letter_gap_time, mlpt_pkg::KIND_GAP, 1'b1, last));
      letters++;
    endfunction

    function void check_interval(interval_t got);
      interval_t want;
      intervals++;
      if (awaited.size() == 0) begin
        report($sformatf("interval %0d arrived with nothing outstanding", intervals));
      end else begin
        want = awaited.pop_front();
        if (got !== want) begin
          report($sformatf({"interval %0d: led %b dur %0d kind %0d lend %b mend %b, ",
                            "wanted led %b dur %0d kind %0d lend %b mend %b"},
                           intervals, got.led_on, got.duration_ms, got.symbol_kind,
                           got.letter_end, got.message_end, want.led_on,
                           want.duration_ms, want.symbol_kind, want.letter_end,
                           want.message_end));
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [mlpt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mlpt_pkg::DUR_W-1:0]     cfg_data;
  logic                           steady;
  int unsigned                    cycles;

  mlpt_in_if  letter_in ();
  mlpt_out_if pulse_out ();

  interval_ledger ledger = new();

  morse_letter_pulse_timer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .letter_in (letter_in),
    .pulse_out (pulse_out)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timed out after %0d cycles with %0d intervals outstanding",
               cycles, ledger.pending());
      $display("morse_letter_pulse_timer_top_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    pulse_out.ready <= steady || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin
    interval_t got;
    if (!rst && pulse_out.valid === 1'b1 && pulse_out.ready === 1'b1) begin
      got.led_on      = pulse_out.led_on;
      got.duration_ms = pulse_out.duration_ms;
      got.symbol_kind = mlpt_pkg::kind_t'(pulse_out.symbol_kind);
      got.letter_end  = pulse_out.letter_end;
      got.message_end = pulse_out.message_end;
      ledger.check_interval(got);
    end
  end

  // Offers one letter, idling first now and then, and returns at the edge
  // where it is taken. Valid is left high for a following item.
  task automatic send_letter(logic [mlpt_pkg::CODE_W-1:0] code, logic last);
    while (!steady && $urandom_range(0, 99) < 12) begin
      letter_in.valid <= 1'b0;
      @(posedge clk);
    end
    letter_in.valid       <= 1'b1;
    letter_in.letter_code <= code;
    letter_in.last_letter <= last;
    @(posedge clk);
    while (letter_in.ready !== 1'b1) begin
      @(posedge clk);
    end
    ledger.note_letter(code, last);
  endtask

  task automatic drain();
    letter_in.valid <= 1'b0;
    while (ledger.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic program_timing(logic [mlpt_pkg::DUR_W-1:0] dot,
                                logic [mlpt_pkg::DUR_W-1:0] dash,
                                logic [mlpt_pkg::DUR_W-1:0] sgap,
                                logic [mlpt_pkg::DUR_W-1:0] lgap);
    mlpt_pkg::cfg_reg_t         regs [4];
    logic [mlpt_pkg::DUR_W-1:0] vals [4];
    regs = '{mlpt_pkg::REG_DOT_TIME, mlpt_pkg::REG_DASH_TIME,
             mlpt_pkg::REG_SYMBOL_GAP_TIME, mlpt_pkg::REG_LETTER_GAP_TIME};
    vals = '{dot, dash, sgap, lgap};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      ledger.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly letters built from dots, dashes and zeros, with some stray digits
  // and the odd code anywhere in the field, oversized ones included.
  function automatic logic [mlpt_pkg::CODE_W-1:0] random_code();
    int unsigned pick;
    int unsigned code;
    int unsigned digit;
    pick = $urandom_range(0, 99);
    code = 0;
    if (pick < 70) begin
      for (int d = 0; d < mlpt_pkg::CODE_DIGITS; d++) begin
        digit = $urandom_range(0, 9);
        if (digit < 4) begin
          digit = 1;
        end else if (digit < 8) begin
          digit = 2;
        end else if (digit < 9) begin
          digit = 0;
        end else begin
          digit = $urandom_range(0, 9);
        end
        code = code * 10 + digit;
      end
    end else if (pick < 85) begin
      code = $urandom_range(0, 16383);
    end else begin
      code = $urandom_range(0, 9999);
    end
    return mlpt_pkg::CODE_W'(code);
  endfunction

  localparam logic [mlpt_pkg::CODE_W-1:0] DIRECTED [22] = '{
    14'd0,    14'd1,    14'd2,    14'd1111, 14'd2222, 14'd1212, 14'd2121,
    14'd9999, 14'd16383, 14'd10000, 14'd12000, 14'd3456, 14'd1000, 14'd2000,
    14'd20,   14'd200,  14'd11,   14'd21,   14'd1112, 14'd2211, 14'd5,
    14'd8191
  };

  initial begin
    rst                   = 1'b1;
    cycles                = 0;
    steady                = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    letter_in.valid       = 1'b0;
    letter_in.letter_code = '0;
    letter_in.last_letter = 1'b0;
    pulse_out.ready       = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed letters run with the reset durations.
    for (int i = 0; i < 22; i++) begin
      send_letter(DIRECTED[i], (i % 3) == 2);
    end
    drain();

    for (int phase = 1; phase <= PHASES; phase++) begin
      case (phase)
        1: program_timing('0, '0, '0, '0);
        2: program_timing('1, '1, '1, '1);
        4: program_timing(16'd1, 16'hFFFF, mlpt_pkg::DUR_W'($urandom_range(0, 65535)), '0);
        default: program_timing(mlpt_pkg::DUR_W'($urandom_range(0, 65535)),
                                mlpt_pkg::DUR_W'($urandom_range(0, 65535)),
                                mlpt_pkg::DUR_W'($urandom_range(0, 65535)),
                                mlpt_pkg::DUR_W'($urandom_range(0, 65535)));
      endcase
      // The third phase runs with neither side ever idling.
      steady <= (phase == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 1 && i == PHASE_ITEMS / 2) begin
          drain();
        end
        send_letter(random_code(), 1'($urandom_range(0, 1)));
      end
      drain();
    end

    steady <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    while (ledger.pending() != 0) begin
      ledger.report("interval still outstanding at the end of the run");
      void'(ledger.awaited.pop_front());
    end

    $display("Sent %0d letters over %0d duration settings; checked %0d intervals.",
             ledger.letters, PHASES + 1, ledger.intervals);
    $display("Mismatches found: %0d.", ledger.faults);
    if (ledger.faults == 0) begin
      $display("morse_letter_pulse_timer_top_tb passed");
    end else begin
      $display("morse_letter_pulse_timer_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mlpt_pkg.sv
hw/rtl/mlpt_in_if.sv
hw/rtl/mlpt_out_if.sv
hw/rtl/mlpt_front.sv
hw/rtl/mlpt_queue.sv
hw/rtl/mlpt_back.sv
hw/rtl/morse_letter_pulse_timer_top.sv
bench/morse_letter_pulse_timer_top_tb.sv
